[design/slm_pkg.sv]
`default_nettype none

package slm_pkg;

  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned COLS_CFG_W = 7;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned NUM_NEIGH  = 8;
  localparam int unsigned NUM_CAND   = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned TDATA_W    = ((SAMPLE_W + ROW_W + COL_W + 7) / 8) * 8;
  localparam int unsigned TUSER_W    = 2;

  typedef enum logic [0:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_reg_e;

  // one window column, index 0 = oldest row, 2 = current row
  typedef logic [2:0][SAMPLE_W-1:0] slm_col_t;
  // window, index 0 = leftmost column
  typedef slm_col_t [2:0] slm_win_t;

  typedef struct packed {
    logic row_hi;
    logic col_hi;
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } slm_jctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                is_max;
    logic                last;
    logic                eof;
  } slm_res_t;

  // neighbor offsets as positions in a 3x3 patch around the center (1,1)
  localparam logic [1:0] NB_ROW [NUM_NEIGH] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] NB_COL [NUM_NEIGH] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

endpackage

`default_nettype wire

[design/slm_col_cell.sv]
`default_nettype none

module slm_col_cell import slm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire slm_col_t col_i,
  output slm_col_t      col_o
);

  slm_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

[design/slm_judge.sv]
`default_nettype none

module slm_judge import slm_pkg::*; (
  input  wire slm_win_t  win_i,
  input  wire slm_jctl_t ctl_i,
  output logic           is_max_o
);

  logic [1:0]          rsel [3];
  logic [1:0]          csel [3];
  logic [SAMPLE_W-1:0] nb [3][3];

  always_comb begin
    rsel[0] = ctl_i.row_hi ? 2'd1 : 2'd0;
    rsel[1] = ctl_i.row_hi ? 2'd2 : 2'd1;
    rsel[2] = 2'd2;
    csel[0] = ctl_i.col_hi ? 2'd1 : 2'd0;
    csel[1] = ctl_i.col_hi ? 2'd2 : 2'd1;
    csel[2] = 2'd2;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nb[i][j] = win_i[csel[j]][rsel[i]];
      end
    end
  end

  always_comb begin
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < NUM_NEIGH; k++) begin
      if ((NB_ROW[k] != 2'd0 || ctl_i.has_up) &&
          (NB_ROW[k] != 2'd2 || ctl_i.has_down) &&
          (NB_COL[k] != 2'd0 || ctl_i.has_left) &&
          (NB_COL[k] != 2'd2 || ctl_i.has_right)) begin
        if (nb[1][1] <= nb[NB_ROW[k]][NB_COL[k]]) begin
          ok = 1'b0;
        end
      end
    end
    is_max_o = ok;
  end

endmodule

`default_nettype wire

[design/slm_out_fifo.sv]
`default_nettype none

module slm_out_fifo import slm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire slm_res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output slm_res_t      data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  slm_res_t         buf_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/strict_local_max_3x3_unit.sv]
// Streaming 3x3 strict local-maximum test over a raster frame.
// Slave stream: one sample per word in s_axis_tdata. Master stream: one
// verdict per word (value, row, column in tdata; is_local_max and
// end_of_frame in tuser; tlast marks the last verdict caused by one sample).
// Frame size comes from the cfg port (index 0 = rows, 1 = columns); any
// write restarts the raster position at (0, 0).
// A sample yields zero to four verdicts: one for most samples past the
// first row, none at the start of an inner row, and extra ones at the row
// end and on the last row.
// Throughput: one sample per cycle while each sample yields at most one
// verdict and the output queue has room; a sample with more verdicts holds
// the input until all are queued, since they enter the queue one per cycle.
// A sample passes stage A and then the window shift before its first verdict
// is written to the queue and shown on the master side.
// A four-entry output queue decouples the sides; when the receiver stalls,
// the queue fills and then the slave side deasserts tready.
// Reset empties the pipeline and queue and sets the frame to 1 x 1; the line
// stores hold no valid data until the first rows pass.
`default_nettype none

module strict_local_max_3x3_unit import slm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_addr_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,   // pixel_value, pixel_row, pixel_col, pad
  output logic                       m_axis_tlast,   // last_of_run
  output logic [TUSER_W-1:0]         m_axis_tuser    // is_local_max, end_of_frame
);

  logic [ROW_W-1:0]      rows_q;
  logic [COLS_CFG_W-1:0] cols_q;
  logic [ROW_W-1:0]      rows_eff;
  logic [COLS_CFG_W-1:0] cols_eff;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic                  last_row, last_col;
  logic                  in_acc;

  logic                  a_vld_q;
  logic [SAMPLE_W-1:0]   a_sample_q;
  logic [ROW_W-1:0]      a_row_q;
  logic [COL_W-1:0]      a_col_q;
  logic                  a_last_row_q, a_last_col_q;

  logic [SAMPLE_W-1:0]   older_mem [MAX_COLS];
  logic [SAMPLE_W-1:0]   newer_mem [MAX_COLS];
  logic [SAMPLE_W-1:0]   older_rd_q, newer_rd_q;
  logic                  bypass;

  slm_col_t              c0, c1, c2;
  slm_win_t              win;
  logic                  shift_en;

  logic [ROW_W-1:0]      w_row_q;
  logic [COL_W-1:0]      w_col_q;
  logic [NUM_CAND-1:0]   pend_q, pend_d, a_mask;
  logic [1:0]            sel;
  logic                  pend_last, push, adv, full, is_max;
  slm_jctl_t             jctl;
  slm_res_t              res, out_res;

  // configuration and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROW_W'(1);
      cols_q <= COLS_CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_ROWS: rows_q <= cfg_wdata_i[ROW_W-1:0];
        REG_FRAME_COLS: cols_q <= cfg_wdata_i[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (rows_q == '0) ? ROW_W'(1) : rows_q;
    if (cols_q == '0) begin
      cols_eff = COLS_CFG_W'(1);
    end else if (cols_q > COLS_CFG_W'(MAX_COLS)) begin
      cols_eff = COLS_CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
  end

  assign last_row      = (row_q == rows_eff - ROW_W'(1));
  assign last_col      = (COLS_CFG_W'(col_q) == cols_eff - COLS_CFG_W'(1));
  assign s_axis_tready = !a_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // stage A: sample taken, line stores read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_sample_q   <= s_axis_tdata;
      a_row_q      <= row_q;
      a_col_q      <= col_q;
      a_last_row_q <= last_row;
      a_last_col_q <= last_col;
    end
  end

  assign shift_en = adv && a_vld_q;
  // single-column frames read the entry that is written in the same cycle
  assign bypass   = shift_en && (a_col_q == col_q);

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      older_mem[a_col_q] <= newer_rd_q;
      newer_mem[a_col_q] <= a_sample_q;
    end
    if (in_acc) begin
      older_rd_q <= bypass ? newer_rd_q : older_mem[col_q];
      newer_rd_q <= bypass ? a_sample_q : newer_mem[col_q];
    end
  end

  // window: three column cells in a chain
  slm_col_cell u_cell2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_en),
    .col_i  ({a_sample_q, newer_rd_q, older_rd_q}),
    .col_o  (c2)
  );

  slm_col_cell u_cell1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_en),
    .col_i  (c2),
    .col_o  (c1)
  );

  slm_col_cell u_cell0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift_en),
    .col_i  (c1),
    .col_o  (c0)
  );

  assign win = {c2, c1, c0};

  // verdicts owed by the window: up-left, up (row end), left (last row), current (last row end)
  always_comb begin
    a_mask[0] = (a_row_q != '0) && (a_col_q != '0);
    a_mask[1] = (a_row_q != '0) && a_last_col_q;
    a_mask[2] = a_last_row_q && (a_col_q != '0);
    a_mask[3] = a_last_row_q && a_last_col_q;
  end

  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign pend_last = ((pend_q & (pend_q - NUM_CAND'(1))) == '0);
  assign push      = (pend_q != '0) && !full;
  assign adv       = (pend_q == '0) || (push && pend_last);

  always_comb begin
    if (adv) begin
      pend_d = a_vld_q ? a_mask : '0;
    end else if (push) begin
      pend_d = pend_q & (pend_q - NUM_CAND'(1));
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      w_row_q <= a_row_q;
      w_col_q <= a_col_q;
    end
  end

  always_comb begin
    jctl.row_hi    = sel[1];
    jctl.col_hi    = sel[0];
    jctl.has_up    = sel[1] ? (w_row_q != '0) : (w_row_q >= ROW_W'(2));
    jctl.has_down  = !sel[1];
    jctl.has_left  = sel[0] ? (w_col_q != '0) : (w_col_q >= COL_W'(2));
    jctl.has_right = !sel[0];
  end

  slm_judge u_judge (
    .win_i    (win),
    .ctl_i    (jctl),
    .is_max_o (is_max)
  );

  always_comb begin
    res.value  = win[{sel[0], !sel[0]}][{sel[1], !sel[1]}];
    res.row    = sel[1] ? w_row_q : w_row_q - ROW_W'(1);
    res.col    = sel[0] ? w_col_q : w_col_q - COL_W'(1);
    res.is_max = is_max;
    res.last   = pend_last;
    res.eof    = &sel;
  end

  slm_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = TDATA_W'({out_res.col, out_res.row, out_res.value});
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = {out_res.eof, out_res.is_max};

endmodule

`default_nettype wire

[design/slm_checker.sv]
`default_nettype none

module slm_checker import slm_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_we_i,
  input wire logic                cfg_addr_i,
  input wire logic [CFG_W-1:0]    cfg_wdata_i,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [SAMPLE_W-1:0] s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [TDATA_W-1:0]  m_axis_tdata,
  input wire logic                m_axis_tlast,
  input wire logic [TUSER_W-1:0]  m_axis_tuser
);

  // the frame's final verdict always closes its run
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("end_of_frame word without tlast");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

  // a word taken at the first edge after reset shows no verdict until it has passed stage A, the window and the queue
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) ##1 !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("verdict shown too early after reset");

endmodule

bind strict_local_max_3x3_unit slm_checker u_slm_checker (.*);

`default_nettype wire
